// ----- hdl/hkr_pkg.sv -----
// Shared constants, status type and US layout lookup for the keyboard report block.
`default_nettype none

package hkr_pkg;

  localparam int unsigned KEY_W      = 8;
  localparam int unsigned MOD_W      = 8;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned LEN_W      = 7;
  localparam logic [KEY_W-1:0] FIRST_KEY  = 8'd4;
  localparam logic [LEN_W-1:0] MIN_REPORT = 7'd8;
  localparam logic [MOD_W-1:0] SHIFT_MASK = 8'h22;

  // Status that the event merger reports back to the top level.
  typedef struct packed {
    logic idle;
    logic freeing;
  } merge_status_t;

  // US layout: returns the character for a usage, 0 when there is none.
  function automatic logic [CHAR_W-1:0] layout_char(input logic [KEY_W-1:0] key,
                                                    input logic shifted);
    logic [KEY_W-1:0] ofs;
    logic [KEY_W-1:0] letter;
    logic [CHAR_W-1:0] ch;
    ofs    = key - FIRST_KEY;
    letter = shifted ? (8'h41 + ofs) : (8'h61 + ofs);
    ch     = '0;
    if (key >= 8'd4 && key <= 8'd29) begin
      ch = letter[CHAR_W-1:0];
    end else begin
      case (key)
        8'd30:   ch = shifted ? 7'h21 : 7'h31;
        8'd31:   ch = shifted ? 7'h40 : 7'h32;
        8'd32:   ch = shifted ? 7'h23 : 7'h33;
        8'd33:   ch = shifted ? 7'h24 : 7'h34;
        8'd34:   ch = shifted ? 7'h25 : 7'h35;
        8'd35:   ch = shifted ? 7'h5E : 7'h36;
        8'd36:   ch = shifted ? 7'h26 : 7'h37;
        8'd37:   ch = shifted ? 7'h2A : 7'h38;
        8'd38:   ch = shifted ? 7'h28 : 7'h39;
        8'd39:   ch = shifted ? 7'h29 : 7'h30;
        8'd40:   ch = 7'h0D;
        8'd42:   ch = shifted ? 7'h00 : 7'h08;
        8'd44:   ch = 7'h20;
        8'd45:   ch = shifted ? 7'h5F : 7'h2D;
        8'd46:   ch = shifted ? 7'h2B : 7'h3D;
        8'd47:   ch = shifted ? 7'h7B : 7'h5B;
        8'd48:   ch = shifted ? 7'h7D : 7'h5D;
        8'd49:   ch = shifted ? 7'h7C : 7'h5C;
        8'd50:   ch = shifted ? 7'h7C : 7'h5C;
        8'd51:   ch = shifted ? 7'h3A : 7'h3B;
        8'd52:   ch = shifted ? 7'h22 : 7'h27;
        8'd53:   ch = shifted ? 7'h7E : 7'h60;
        8'd54:   ch = shifted ? 7'h3C : 7'h2C;
        8'd55:   ch = shifted ? 7'h3E : 7'h2E;
        8'd56:   ch = shifted ? 7'h3F : 7'h2F;
        default: ch = '0;
      endcase
    end
    return ch;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/hkr_lane.sv -----
// One key slot lane: finds a release of the old key and a press of the new key.
`default_nettype none

module hkr_lane #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic [hkr_pkg::KEY_W-1:0]                old_key_i,
  input  wire logic [hkr_pkg::KEY_W-1:0]                new_key_i,
  input  wire logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] old_keys_i,
  input  wire logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] new_keys_i,
  output logic                                          release_o,
  output logic                                          press_o
);

  logic old_in_new;
  logic new_in_old;

  always_comb begin
    old_in_new = 1'b0;
    new_in_old = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (new_keys_i[i] == old_key_i) old_in_new = 1'b1;
      if (old_keys_i[i] == new_key_i) new_in_old = 1'b1;
    end
  end

  // Usages below the first real key never cause events.
  assign release_o = (old_key_i >= hkr_pkg::FIRST_KEY) && !old_in_new;
  assign press_o   = (new_key_i >= hkr_pkg::FIRST_KEY) && !new_in_old;

endmodule

`default_nettype wire

// ----- hdl/hkr_merge.sv -----
// Event merger: holds one report's lane results and sends its events in order.
`default_nettype none

module hkr_merge #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     load_i,
  input  wire logic [KEY_SLOTS-1:0]                     release_i,
  input  wire logic [KEY_SLOTS-1:0]                     press_i,
  input  wire logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] old_keys_i,
  input  wire logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] new_keys_i,
  input  wire logic [hkr_pkg::MOD_W-1:0]                mod_i,
  output hkr_pkg::merge_status_t                        status_o,
  input  wire logic                                     out_ready_i,
  output logic                                          out_valid_o,
  output logic [hkr_pkg::KEY_W-1:0]                     out_key_o,
  output logic                                          out_press_o,
  output logic [hkr_pkg::MOD_W-1:0]                     out_mod_o,
  output logic [hkr_pkg::CHAR_W-1:0]                    out_char_o,
  output logic                                          out_has_char_o,
  output logic                                          out_last_o
);

  localparam int unsigned CAND = 2 * KEY_SLOTS;

  // Candidate 2*i is the release of slot i, candidate 2*i+1 its press.
  logic [CAND-1:0]                          mask_d, mask_q;
  logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] old_q;
  logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] new_q;
  logic [hkr_pkg::MOD_W-1:0]                mod_q;

  logic [CAND-1:0]            pick;
  logic [CAND-1:0]            rest;
  logic [hkr_pkg::KEY_W-1:0]  pick_key;
  logic                       pick_press;
  logic                       shifted;
  logic [hkr_pkg::CHAR_W-1:0] pick_char;
  logic                       advance;

  logic                       out_valid_d, out_valid_q;
  logic [hkr_pkg::KEY_W-1:0]  out_key_q;
  logic                       out_press_q;
  logic [hkr_pkg::MOD_W-1:0]  out_mod_q;
  logic [hkr_pkg::CHAR_W-1:0] out_char_q;
  logic                       out_last_q;

  assign pick    = mask_q & (~mask_q + CAND'(1));
  assign rest    = mask_q & ~pick;
  assign advance = (|mask_q) && (!out_valid_q || out_ready_i);

  always_comb begin
    pick_key   = '0;
    pick_press = 1'b0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (pick[2*i])   pick_key = pick_key | old_q[i];
      if (pick[2*i+1]) begin
        pick_key   = pick_key | new_q[i];
        pick_press = 1'b1;
      end
    end
  end

  assign shifted   = |(mod_q & hkr_pkg::SHIFT_MASK);
  assign pick_char = pick_press ? hkr_pkg::layout_char(pick_key, shifted) : '0;

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        mask_d[2*i]   = release_i[i];
        mask_d[2*i+1] = press_i[i];
      end
    end else if (advance) begin
      mask_d = rest;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      old_q <= old_keys_i;
      new_q <= new_keys_i;
      mod_q <= mod_i;
    end
    if (advance) begin
      out_key_q   <= pick_key;
      out_press_q <= pick_press;
      out_mod_q   <= pick_press ? mod_q : '0;
      out_char_q  <= pick_char;
      out_last_q  <= (rest == '0);
    end
  end

  assign status_o.idle    = (mask_q == '0);
  assign status_o.freeing = advance && (rest == '0);

  assign out_valid_o    = out_valid_q;
  assign out_key_o      = out_key_q;
  assign out_press_o    = out_press_q;
  assign out_mod_o      = out_mod_q;
  assign out_char_o     = out_char_q;
  assign out_has_char_o = (out_char_q != '0);
  assign out_last_o     = out_last_q;

endmodule

`default_nettype wire

// ----- hdl/hid_keyboard_report_to_key_events.sv -----
// Top level: boot keyboard report in, key press and release events out.
// A taken report's events wait in the event buffer and move from there into the output register.
// Throughput: one event per cycle while m_axis_tready is high.
// A report is taken in the cycle its predecessor's last event moves out, so back-to-back.
// Short reports and reports causing no event leave the event buffer empty.
// Reset clears the previous keys to zero and empties the event buffer and output register.
`default_nettype none

module hid_keyboard_report_to_key_events #(
  parameter int unsigned KEY_SLOTS = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Report request, from bit 0: report_bytes[6:0], modifier_bits[14:7],
  // then key_slot_0 .. key_slot_N 8 bits each, zero filled to whole bytes.
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [((hkr_pkg::LEN_W + hkr_pkg::MOD_W + hkr_pkg::KEY_W * KEY_SLOTS + 7) / 8)
                     * 8 - 1:0]      s_axis_tdata,
  // Event request, from bit 0: event_key[7:0], event_modifier[15:8],
  // ascii_char[22:16], has_char[23].
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [23:0]                m_axis_tdata,
  // is_press: 1 for a key press, 0 for a release.
  output logic                       m_axis_tuser,
  // last_event: set on the final event of a report.
  output logic                       m_axis_tlast
);

  localparam int unsigned KEY_BASE = hkr_pkg::LEN_W + hkr_pkg::MOD_W;

  // Field extraction from the report request.
  logic [hkr_pkg::LEN_W-1:0]                report_bytes;
  logic [hkr_pkg::MOD_W-1:0]                modifier_bits;
  logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] key_slots;

  assign report_bytes  = s_axis_tdata[hkr_pkg::LEN_W-1:0];
  assign modifier_bits = s_axis_tdata[hkr_pkg::LEN_W +: hkr_pkg::MOD_W];

  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_unpack
    assign key_slots[g] = s_axis_tdata[KEY_BASE + g * hkr_pkg::KEY_W +: hkr_pkg::KEY_W];
  end

  // Keys of the previous full-length report; compared against each new report.
  logic [KEY_SLOTS-1:0][hkr_pkg::KEY_W-1:0] prev_d, prev_q;

  hkr_pkg::merge_status_t status;
  logic                   accept;
  logic                   load;
  logic [KEY_SLOTS-1:0]   release_hit;
  logic [KEY_SLOTS-1:0]   press_hit;

  // A new report may enter once the event buffer is empty or hands over its last event.
  assign s_axis_tready = status.idle || status.freeing;
  assign accept        = s_axis_tvalid && s_axis_tready;
  // Short reports are consumed without events and leave the previous keys alone.
  assign load          = accept && (report_bytes >= hkr_pkg::MIN_REPORT);

  // One lane per key slot, all comparing in the same cycle.
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_lane
    hkr_lane #(
      .KEY_SLOTS (KEY_SLOTS)
    ) u_lane (
      .old_key_i  (prev_q[g]),
      .new_key_i  (key_slots[g]),
      .old_keys_i (prev_q),
      .new_keys_i (key_slots),
      .release_o  (release_hit[g]),
      .press_o    (press_hit[g])
    );
  end

  always_comb begin
    prev_d = prev_q;
    if (load) begin
      prev_d = key_slots;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else begin
      prev_q <= prev_d;
    end
  end

  // The merger keeps the lane results and emits them in slot order,
  // release before press within a slot.
  logic [hkr_pkg::KEY_W-1:0]  event_key;
  logic                       is_press;
  logic [hkr_pkg::MOD_W-1:0]  event_modifier;
  logic [hkr_pkg::CHAR_W-1:0] ascii_char;
  logic                       has_char;
  logic                       last_event;

  hkr_merge #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (load),
    .release_i      (release_hit),
    .press_i        (press_hit),
    .old_keys_i     (prev_q),
    .new_keys_i     (key_slots),
    .mod_i          (modifier_bits),
    .status_o       (status),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_key_o      (event_key),
    .out_press_o    (is_press),
    .out_mod_o      (event_modifier),
    .out_char_o     (ascii_char),
    .out_has_char_o (has_char),
    .out_last_o     (last_event)
  );

  assign m_axis_tdata = {has_char, ascii_char, event_modifier, event_key};
  assign m_axis_tuser = is_press;
  assign m_axis_tlast = last_event;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking bench for the keyboard report to key event block.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned NUM_SLOTS     = 6;
  localparam int unsigned REPORT_W      =
    ((hkr_pkg::LEN_W + hkr_pkg::MOD_W + hkr_pkg::KEY_W * NUM_SLOTS + 7) / 8) * 8;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 20;
  localparam logic [hkr_pkg::KEY_W-1:0] TABLE_END = 8'd57;

  // US layout columns, first character in the top byte.
  localparam logic [8*10-1:0] DIGIT_PLAIN = "1234567890";
  localparam logic [8*10-1:0] DIGIT_SHIFT = "!@#$%^&*()";
  // Usages 40 to 56: enter, escape, backspace, tab, space, then punctuation.
  localparam logic [8*17-1:0] PUNCT_PLAIN = {8'h0D, 8'h00, 8'h08, 8'h00, " -=[]\\\\;'`,./"};
  localparam logic [8*17-1:0] PUNCT_SHIFT = {8'h0D, 8'h00, 8'h00, 8'h00, " _+{}||:\"~<>?"};

  typedef struct packed {
    logic                                     drain_first;
    logic [NUM_SLOTS-1:0][hkr_pkg::KEY_W-1:0] keys;
    logic [hkr_pkg::MOD_W-1:0]                mods;
    logic [hkr_pkg::LEN_W-1:0]                nbytes;
  } kbd_report_t;

  typedef struct packed {
    logic [hkr_pkg::KEY_W-1:0]  key;
    logic                       press;
    logic [hkr_pkg::MOD_W-1:0]  mods;
    logic [hkr_pkg::CHAR_W-1:0] ch;
    logic                       has_ch;
    logic                       last;
  } kbd_event_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [REPORT_W-1:0] s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  logic [NUM_SLOTS-1:0][hkr_pkg::KEY_W-1:0] held_keys    = '0;
  logic [NUM_SLOTS-1:0][hkr_pkg::KEY_W-1:0] typing_slots = '0;
  kbd_event_t  expected_events[$];
  kbd_report_t pending_reports[$];
  kbd_report_t report_on_bus = '0;
  int unsigned reports_sent  = 0;
  int unsigned reports_taken = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned error_count   = 0;
  int unsigned idle_cycles   = 0;

  hid_keyboard_report_to_key_events #(
    .KEY_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  function automatic logic [hkr_pkg::CHAR_W-1:0] us_char(
      input logic [hkr_pkg::KEY_W-1:0] usage, input logic shift);
    int ofs;
    logic [7:0] code;
    code = 8'h00;
    if (usage >= hkr_pkg::FIRST_KEY && usage <= 8'd29) begin
      ofs  = int'(usage) - int'(hkr_pkg::FIRST_KEY);
      code = (shift ? 8'h41 : 8'h61) + 8'(ofs);
    end else if (usage >= 8'd30 && usage <= 8'd39) begin
      ofs  = int'(usage) - 30;
      code = shift ? DIGIT_SHIFT[8*(9-ofs) +: 8] : DIGIT_PLAIN[8*(9-ofs) +: 8];
    end else if (usage >= 8'd40 && usage < TABLE_END) begin
      ofs  = int'(usage) - 40;
      code = shift ? PUNCT_SHIFT[8*(16-ofs) +: 8] : PUNCT_PLAIN[8*(16-ofs) +: 8];
    end
    return code[hkr_pkg::CHAR_W-1:0];
  endfunction

  function automatic bit slot_has(input logic [NUM_SLOTS-1:0][hkr_pkg::KEY_W-1:0] list,
                                  input logic [hkr_pkg::KEY_W-1:0] key);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (list[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  // Releases carry no modifier and no character; presses are looked up with
  // either shift bit selecting the shifted column.
  function automatic kbd_event_t make_event(input logic [hkr_pkg::KEY_W-1:0] key,
                                            input logic press,
                                            input logic [hkr_pkg::MOD_W-1:0] mods);
    kbd_event_t ev;
    ev.key    = key;
    ev.press  = press;
    ev.mods   = press ? mods : '0;
    ev.ch     = press ? us_char(key, (mods & hkr_pkg::SHIFT_MASK) != '0) : '0;
    ev.has_ch = ev.ch != '0;
    ev.last   = 1'b0;
    return ev;
  endfunction

  // Per slot: release of the old key first, then press of the new one.
  task automatic predict_key_events(input kbd_report_t r);
    int unsigned first_new;
    first_new = expected_events.size();
    if (r.nbytes < hkr_pkg::MIN_REPORT) return;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (held_keys[i] >= hkr_pkg::FIRST_KEY && !slot_has(r.keys, held_keys[i]))
        expected_events.push_back(make_event(held_keys[i], 1'b0, r.mods));
      if (r.keys[i] >= hkr_pkg::FIRST_KEY && !slot_has(held_keys, r.keys[i]))
        expected_events.push_back(make_event(r.keys[i], 1'b1, r.mods));
    end
    if (expected_events.size() > first_new)
      expected_events[expected_events.size()-1].last = 1'b1;
    held_keys = r.keys;
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch at %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  task automatic check_key_event(input kbd_event_t got);
    kbd_event_t want;
    if (expected_events.size() == 0) begin
      report_mismatch("event with none pending, key", got.key, 0);
      return;
    end
    want = expected_events.pop_front();
    if (got.key != want.key)       report_mismatch("event_key", got.key, want.key);
    if (got.press != want.press)   report_mismatch("is_press", got.press, want.press);
    if (got.mods != want.mods)     report_mismatch("event_modifier", got.mods, want.mods);
    if (got.ch != want.ch)         report_mismatch("ascii_char", got.ch, want.ch);
    if (got.has_ch != want.has_ch) report_mismatch("has_char", got.has_ch, want.has_ch);
    if (got.last != want.last)     report_mismatch("last_event", got.last, want.last);
  endtask

  task automatic queue_report(input logic [hkr_pkg::LEN_W-1:0] nbytes,
                              input logic [hkr_pkg::MOD_W-1:0] mods,
                              input logic [hkr_pkg::KEY_W-1:0] k0,
                              input logic [hkr_pkg::KEY_W-1:0] k1,
                              input logic [hkr_pkg::KEY_W-1:0] k2,
                              input logic [hkr_pkg::KEY_W-1:0] k3,
                              input logic [hkr_pkg::KEY_W-1:0] k4,
                              input logic [hkr_pkg::KEY_W-1:0] k5,
                              input logic drain_first);
    kbd_report_t r;
    r.nbytes      = nbytes;
    r.mods        = mods;
    r.keys        = {k5, k4, k3, k2, k1, k0};
    r.drain_first = drain_first;
    pending_reports.push_back(r);
  endtask

  // Mostly plausible typing: a few slots change per report, held keys stay.
  // The rest is noise in every field and short reports that must be ignored.
  task automatic feed_random_reports(input int unsigned want);
    kbd_report_t r;
    int unsigned counted;
    int unsigned pick;
    counted = 0;
    while (counted < want) begin
      r.drain_first = ($urandom_range(0, 24) == 0);
      case ($urandom_range(0, 4))
        0:       r.mods = 8'h00;
        1:       r.mods = 8'h02;
        2:       r.mods = 8'h20;
        3:       r.mods = 8'h22;
        default: r.mods = 8'($urandom_range(0, 255));
      endcase
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
          if ($urandom_range(0, 3) == 0) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)      typing_slots[s] = '0;
            else if (pick < 90) typing_slots[s] = 8'($urandom_range(4, 56));
            else if (pick < 95) typing_slots[s] = 8'($urandom_range(57, 255));
            else                typing_slots[s] = 8'($urandom_range(0, 3));
          end
        end
        // Occasionally the same usage lands in two slots.
        if ($urandom_range(0, 15) == 0)
          typing_slots[$urandom_range(0, NUM_SLOTS-1)] =
            typing_slots[$urandom_range(0, NUM_SLOTS-1)];
        r.keys   = typing_slots;
        r.nbytes = ($urandom_range(0, 4) == 0) ? 7'($urandom_range(9, 64))
                                               : hkr_pkg::MIN_REPORT;
      end else begin
        for (int s = 0; s < NUM_SLOTS; s++) r.keys[s] = 8'($urandom_range(0, 255));
        r.nbytes = (pick < 86) ? 7'($urandom_range(8, 64)) : 7'($urandom_range(0, 7));
      end
      pending_reports.push_back(r);
      if (r.nbytes >= hkr_pkg::MIN_REPORT) counted++;
    end
    while (pending_reports.size() != 0 || s_axis_tvalid) @(negedge clk_i);
  endtask

  // Sender and receiver: inputs change only on the falling edge.
  // A request stays on the bus until the monitor has seen it taken.
  always @(negedge clk_i) begin : drive_side
    kbd_report_t nxt;
    logic        next_valid;
    if (rst_ni) begin
      next_valid = (reports_sent != reports_taken);
      if (!next_valid && pending_reports.size() != 0 &&
          $urandom_range(0, 99) >= send_idle_pct &&
          !(pending_reports[0].drain_first && expected_events.size() != 0)) begin
        nxt           = pending_reports.pop_front();
        report_on_bus <= nxt;
        s_axis_tdata  <= REPORT_W'({nxt.keys, nxt.mods, nxt.nbytes});
        next_valid    = 1'b1;
        reports_sent++;
      end
      s_axis_tvalid <= next_valid;
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Both handshakes are sampled on the rising edge; the watchdog counts
  // consecutive cycles in which neither side moves a request.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_key_events(report_on_bus);
        reports_taken++;
      end
      if (m_axis_tvalid && m_axis_tready)
        check_key_event({m_axis_tdata[7:0], m_axis_tuser, m_axis_tdata[15:8],
                         m_axis_tdata[22:16], m_axis_tdata[23], m_axis_tlast});
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct = 38;
    recv_idle_pct = 78;
    // Short reports are dropped without touching the held keys.
    queue_report(7'd0, 8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 1'b0);
    queue_report(7'd7, 8'hFF, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    queue_report(7'd8, 8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 1'b0);
    queue_report(7'd7, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    // Same keys again: accepted, but nothing changed.
    queue_report(7'd8, 8'h00, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd9, 1'b0);
    // Twelve events, with empty table entries under left shift; sent only
    // once every earlier event is out.
    queue_report(7'd64, 8'h02, 8'd56, 8'd40, 8'd42, 8'd43, 8'd44, 8'd45, 1'b1);
    // Rollover and reserved codes never press anything, only release.
    queue_report(7'd8, 8'h20, 8'd0, 8'd1, 8'd2, 8'd3, 8'd0, 8'd0, 1'b0);
    // Backspace, untranslated usages and a duplicated key.
    queue_report(7'd8, 8'h00, 8'd42, 8'd57, 8'd255, 8'd100, 8'd4, 8'd4, 1'b0);
    queue_report(7'd8, 8'hFF, 8'd4, 8'd4, 8'd30, 8'd39, 8'd49, 8'd50, 1'b0);
    queue_report(7'd8, 8'hDD, 8'd29, 8'd53, 8'd54, 8'd55, 8'd56, 8'd47, 1'b0);
    // Sweep every usage of the table and a few past its end.
    for (int g = 0; g < 10; g++)
      queue_report(7'd8, (g % 3 == 0) ? 8'h00 : ((g % 3 == 1) ? 8'h02 : 8'h20),
                   8'(4 + 6*g), 8'(5 + 6*g), 8'(6 + 6*g), 8'(7 + 6*g), 8'(8 + 6*g),
                   8'(9 + 6*g), 1'b0);
    queue_report(7'd8, 8'h00, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    feed_random_reports(60);

    send_idle_pct = 78;
    recv_idle_pct = 38;
    feed_random_reports(60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    feed_random_reports(60);

    while (expected_events.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/hkr_pkg.sv
hdl/hkr_lane.sv
hdl/hkr_merge.sv
hdl/hid_keyboard_report_to_key_events.sv
test/tb.sv
